@@ rtl/swmf_pkg.sv @@
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared types and constants for the running median filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WSIZE_W  = 5;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [WSIZE_W-1:0]  wsize_t;

  // Window size after reset
  localparam wsize_t WSIZE_RESET = wsize_t'(16);

  // Per-cell control, driven by the sequencer in the top level
  typedef struct packed {
    logic shift;  // advance the history and load the sort register
    logic fill;   // cell lies inside the active window
    logic lo;     // lower member of a compare pair: keep the minimum
    logic hi;     // upper member of a compare pair: keep the maximum
  } cell_ctrl_t;

endpackage

@@ rtl/swmf_if.sv @@
// ----------------------------------------------------------------------------
// swmf_if
// Valid/ready channels for samples, medians and the window size register.
// ----------------------------------------------------------------------------
interface swmf_sample_if;
  logic              valid;
  logic              ready;
  swmf_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swmf_median_if;
  logic              valid;
  logic              ready;
  swmf_pkg::sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

interface swmf_cfg_if;
  logic             valid;
  logic             ready;
  swmf_pkg::wsize_t window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

@@ rtl/sliding_window_median_filter.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median_filter
// Running median over the newest window_size unsigned 16-bit samples.
// ----------------------------------------------------------------------------
// A user's view: every accepted sample item yields exactly one median item.
// The filter keeps the last MAX_WINDOW samples in a chain of cells (reset to
// zero, so early medians count those zeros). The median is the element at
// rank n/2 of the newest n samples sorted ascending, n being window_size
// clamped to 1..MAX_WINDOW (zero acts as 1). For each item, the accepting
// edge shifts the history and fills the sort slots, odd-even transposition
// rounds then run across the chain (each cell but the two end cells compares
// with a neighbour in every round), and the median is registered once the
// output register is free. No new sample is taken while an item is in
// flight. The next item is taken once the result is registered, even if the
// consumer has not yet taken it. Write window_size only while idle; the
// configuration channel is always ready.
// ----------------------------------------------------------------------------
module sliding_window_median_filter #(
  parameter int MAX_WINDOW = 16
) (
  input  logic clk,
  input  logic rst,
  swmf_cfg_if.sink      cfg,
  swmf_sample_if.sink   samples,
  swmf_median_if.source medians
);

  localparam int NW = $clog2(MAX_WINDOW + 1);
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = (NW > swmf_pkg::WSIZE_W) ? NW : swmf_pkg::WSIZE_W;

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SORT   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  swmf_pkg::wsize_t  window_size;
  logic [NW-1:0]     rnd;
  logic [NW-1:0]     n_eff;
  logic [CW-1:0]     ws_ext;
  logic [IW-1:0]     mid;
  swmf_pkg::sample_t med;
  logic              med_valid;
  logic              accept;
  logic              in_sort;
  logic              load_out;

  swmf_pkg::sample_t    hist_q  [MAX_WINDOW];
  swmf_pkg::sample_t    sort_q  [MAX_WINDOW];
  swmf_pkg::cell_ctrl_t cell_ctrl [MAX_WINDOW];

  // Configuration: always ready; written only while idle by the user, which the block does not enforce.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swmf_pkg::WSIZE_RESET;
    end else if (cfg.valid) begin
      window_size <= cfg.window_size;
    end
  end

  // Clamp the register to 1..MAX_WINDOW.
  assign ws_ext = CW'(window_size);

  always_comb begin
    if (ws_ext == '0) begin
      n_eff = NW'(1);
    end else if (ws_ext > CW'(MAX_WINDOW)) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(ws_ext);
    end
  end

  assign mid = IW'(n_eff >> 1);

  // Handshakes
  assign samples.ready  = (state == ST_IDLE);
  assign accept         = samples.valid && samples.ready;
  assign in_sort        = (state == ST_SORT);
  assign load_out       = (state == ST_RESULT) && (!med_valid || medians.ready);
  assign medians.valid  = med_valid;
  assign medians.median = med;

  // Sequencer: idle -> sort rounds -> result
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SORT;
        end
      end
      ST_SORT: begin
        if (rnd == n_eff - NW'(1)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        rnd <= '0;
      end else if (in_sort) begin
        rnd <= rnd + NW'(1);
      end
    end
  end

  // Output register: hold the median until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      med_valid <= 1'b0;
    end else if (load_out) begin
      med_valid <= 1'b1;
    end else if (medians.ready) begin
      med_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      med <= sort_q[mid];
    end
  end

  // Cell chain: history shifts towards higher index; sort pairs alternate
  // between even and odd boundaries on successive rounds.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    localparam bit PAR   = (i % 2) != 0;
    localparam bit FIRST = (i == 0);
    localparam bit LAST  = (i == MAX_WINDOW - 1);

    swmf_pkg::sample_t hist_in;
    swmf_pkg::sample_t left;
    swmf_pkg::sample_t right;

    if (FIRST) begin : g_head
      assign hist_in = samples.sample;
      assign left    = '0;
    end else begin : g_body
      assign hist_in = hist_q[i-1];
      assign left    = sort_q[i-1];
    end

    if (LAST) begin : g_tail
      assign right = '1;
    end else begin : g_next
      assign right = sort_q[i+1];
    end

    assign cell_ctrl[i].shift = accept;
    assign cell_ctrl[i].fill  = NW'(i) < n_eff;
    assign cell_ctrl[i].lo    = in_sort && (PAR == rnd[0]) && !LAST;
    assign cell_ctrl[i].hi    = in_sort && (PAR != rnd[0]) && !FIRST;

    swmf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (cell_ctrl[i]),
      .hist_in (hist_in),
      .left    (left),
      .right   (right),
      .hist    (hist_q[i]),
      .sorted  (sort_q[i])
    );
  end

endmodule

@@ rtl/swmf_cell.sv @@
// ----------------------------------------------------------------------------
// swmf_cell
// One cell of the filter chain: a history tap and one odd-even sort slot.
// ----------------------------------------------------------------------------
module swmf_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  swmf_pkg::cell_ctrl_t ctrl,
  input  swmf_pkg::sample_t    hist_in,
  input  swmf_pkg::sample_t    left,
  input  swmf_pkg::sample_t    right,
  output swmf_pkg::sample_t    hist,
  output swmf_pkg::sample_t    sorted
);

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (ctrl.shift) begin
      hist <= hist_in;
    end
  end

  // Cells outside the window load the top value so they never move.
  always_ff @(posedge clk) begin
    priority if (ctrl.shift) begin
      sorted <= ctrl.fill ? hist_in : '1;
    end else if (ctrl.lo) begin
      sorted <= (right < sorted) ? right : sorted;
    end else if (ctrl.hi) begin
      sorted <= (left > sorted) ? left : sorted;
    end else begin
      sorted <= sorted;
    end
  end

endmodule

@@ rtl/swmf_checker.sv @@
// ----------------------------------------------------------------------------
// swmf_checker
// Port-level checks for the running median filter, bound to the top level.
// ----------------------------------------------------------------------------
module swmf_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input swmf_pkg::sample_t out_median,
  input logic              cfg_ready
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_median))
    else $error("median changed or dropped while stalled");

  // One item in flight: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while sorting");

  // Sorting lies between an accept and its result, so no result appears at once
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("median raised straight after an accept");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && cfg_ready)
    else $error("output valid after reset");

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (medians.valid),
  .out_ready  (medians.ready),
  .out_median (medians.median),
  .cfg_ready  (cfg.ready)
);
